// ===== sv/agrl_pkg.sv =====
// Shared constants and types for the antenna gain range lookup unit.
// This package has no dependencies.
package agrl_pkg;

    localparam int ELEV_ENTRIES_DEF = 64;
    localparam int BEAR_ENTRIES_DEF = 1024;

    localparam logic signed [15:0] BEARING_WRAP = 16'sd360;

    typedef enum logic [1:0] {
        CMD_ELEV  = 2'd0,
        CMD_BEAR  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_ORDER = 2'd2,
        STATUS_RSVD  = 2'd3
    } t_status;

endpackage

// ===== sv/agrl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the elevation and bearing tables.
module agrl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/antenna_gain_range_lookup_unit.sv =====
// Antenna gain range lookup: a load or clear request returns its result at the edge after
// acceptance. A query binary-searches the elevation table, then the selected bearing segment,
// one compare per cycle through a shared unit fed by one RAM read port per table.
// One request is in work at a time. Synchronous reset clears the counts and missing gain;
// table contents are left as they are and need no clearing pass.
module antenna_gain_range_lookup_unit #(
    parameter int ELEV_ENTRIES = agrl_pkg::ELEV_ENTRIES_DEF,
    parameter int BEAR_ENTRIES = agrl_pkg::BEAR_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [15:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [15:0] i_range_key,
    input  logic signed [15:0] i_entry_gain,
    input  logic               i_entry_is_gap,
    input  logic signed [15:0] i_query_bearing,
    input  logic signed [15:0] i_query_elevation,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_gain_out,
    output logic               o_hit,
    output logic [1:0]         o_status
);

    localparam int EA = $clog2(ELEV_ENTRIES);
    localparam int EC = $clog2(ELEV_ENTRIES + 1);
    localparam int BA = $clog2(BEAR_ENTRIES);
    localparam int BC = $clog2(BEAR_ENTRIES + 1);
    localparam int SW = (BC > EC) ? BC : EC;
    localparam int EW = 16 + 1 + BC;
    localparam int BW = 16 + 16 + 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_E_SRCH = 6'b000010,
        ST_E_SEG0 = 6'b000100,
        ST_E_SEG1 = 6'b001000,
        ST_B_SRCH = 6'b010000,
        ST_B_GAIN = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [EC-1:0] r_elev_count, n_elev_count;
    logic [BC-1:0] r_bear_count, n_bear_count;
    logic signed [15:0] r_missing_gain;
    logic r_out_valid, n_out_valid;

    logic signed [15:0] r_last_elev_key, n_last_elev_key;
    logic [BC-1:0] r_last_seg_start, n_last_seg_start;
    logic signed [15:0] r_last_bear_key, n_last_bear_key;
    logic signed [15:0] r_q_elev, n_q_elev;
    logic signed [15:0] r_q_bear, n_q_bear;
    logic [SW-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [SW-1:0] r_seg_end, n_seg_end;
    logic signed [15:0] r_gain, n_gain;
    logic r_hit, n_hit;
    logic [1:0] r_status, n_status;

    logic accept;
    logic e_we, b_we;
    logic [EA-1:0] e_raddr;
    logic [BA-1:0] b_raddr;
    logic [EW-1:0] e_wdata, e_rdata;
    logic [BW-1:0] b_wdata, b_rdata;

    logic signed [15:0] e_key, b_key, b_gain;
    logic e_gap, b_gap;
    logic [BC-1:0] e_start;

    logic signed [15:0] s_key, s_target;
    logic s_ge, s_more;
    logic [SW-1:0] s_nlo, s_nhi, s_nmid, s_end, s_next;
    logic [SW:0] s_sum, s_sum_end;

    agrl_ram #(.WIDTH(EW), .DEPTH(ELEV_ENTRIES)) u_elev_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_elev_count[EA-1:0]),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    agrl_ram #(.WIDTH(BW), .DEPTH(BEAR_ENTRIES)) u_bear_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (r_bear_count[BA-1:0]),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    assign e_wdata = {i_range_key, i_entry_is_gap, r_bear_count};
    assign b_wdata = {i_range_key, i_entry_gain, i_entry_is_gap};

    assign e_key   = $signed(e_rdata[EW-1 -: 16]);
    assign e_gap   = e_rdata[BC];
    assign e_start = e_rdata[BC-1:0];
    assign b_key   = $signed(b_rdata[BW-1 -: 16]);
    assign b_gain  = $signed(b_rdata[16:1]);
    assign b_gap   = b_rdata[0];

    // Shared search step: narrows [lo, hi) toward the first key at or above the target.
    assign s_key     = (r_state == ST_E_SRCH) ? e_key : b_key;
    assign s_target  = (r_state == ST_E_SRCH) ? r_q_elev : r_q_bear;
    assign s_ge      = s_key >= s_target;
    assign s_nlo     = s_ge ? r_lo : r_mid + SW'(1);
    assign s_nhi     = s_ge ? r_mid : r_hi;
    assign s_sum     = {1'b0, s_nlo} + {1'b0, s_nhi};
    assign s_nmid    = s_sum[SW:1];
    assign s_more    = s_nlo < s_nhi;
    assign s_next    = r_mid + SW'(1);
    assign s_end     = (s_next < SW'(r_elev_count)) ? SW'(e_start) : SW'(r_bear_count);
    assign s_sum_end = {1'b0, r_lo} + {1'b0, s_end};

    always_comb begin
        n_state          = r_state;
        n_elev_count     = r_elev_count;
        n_bear_count     = r_bear_count;
        n_out_valid      = r_out_valid && i_out_stall;
        n_last_elev_key  = r_last_elev_key;
        n_last_seg_start = r_last_seg_start;
        n_last_bear_key  = r_last_bear_key;
        n_q_elev         = r_q_elev;
        n_q_bear         = r_q_bear;
        n_lo             = r_lo;
        n_hi             = r_hi;
        n_mid            = r_mid;
        n_seg_end        = r_seg_end;
        n_gain           = r_gain;
        n_hit            = r_hit;
        n_status         = r_status;
        e_we             = 1'b0;
        b_we             = 1'b0;
        e_raddr          = r_mid[EA-1:0];
        b_raddr          = r_mid[BA-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_gain   = '0;
                    n_hit    = 1'b0;
                    n_status = agrl_pkg::STATUS_OK;
                    unique case (i_cmd)
                        agrl_pkg::CMD_ELEV: begin
                            n_out_valid = 1'b1;
                            if (r_elev_count == EC'(ELEV_ENTRIES)) begin
                                n_status = agrl_pkg::STATUS_FULL;
                            end else if (r_elev_count != '0 &&
                                         i_range_key <= r_last_elev_key) begin
                                n_status = agrl_pkg::STATUS_ORDER;
                            end else begin
                                e_we             = 1'b1;
                                n_elev_count     = r_elev_count + EC'(1);
                                n_last_elev_key  = i_range_key;
                                n_last_seg_start = r_bear_count;
                            end
                        end
                        agrl_pkg::CMD_BEAR: begin
                            n_out_valid = 1'b1;
                            if (r_bear_count == BC'(BEAR_ENTRIES)) begin
                                n_status = agrl_pkg::STATUS_FULL;
                            end else if (r_elev_count == '0) begin
                                n_status = agrl_pkg::STATUS_ORDER;
                            end else if (r_bear_count > r_last_seg_start &&
                                         i_range_key <= r_last_bear_key) begin
                                n_status = agrl_pkg::STATUS_ORDER;
                            end else begin
                                b_we            = 1'b1;
                                n_bear_count    = r_bear_count + BC'(1);
                                n_last_bear_key = i_range_key;
                            end
                        end
                        agrl_pkg::CMD_QUERY: begin
                            n_q_elev = i_query_elevation;
                            n_q_bear = (i_query_bearing == agrl_pkg::BEARING_WRAP) ?
                                       16'sd0 : i_query_bearing;
                            n_lo     = '0;
                            n_hi     = SW'(r_elev_count);
                            n_mid    = SW'(r_elev_count >> 1);
                            e_raddr  = n_mid[EA-1:0];
                            if (r_elev_count == '0) begin
                                n_out_valid = 1'b1;
                                n_gain      = r_missing_gain;
                            end else begin
                                n_state = ST_E_SRCH;
                            end
                        end
                        agrl_pkg::CMD_CLEAR: begin
                            n_out_valid  = 1'b1;
                            n_elev_count = '0;
                            n_bear_count = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_E_SRCH: begin
                if (s_more) begin
                    n_lo    = s_nlo;
                    n_hi    = s_nhi;
                    n_mid   = s_nmid;
                    e_raddr = s_nmid[EA-1:0];
                end else if (s_nlo == SW'(r_elev_count)) begin
                    n_out_valid = 1'b1;
                    n_gain      = r_missing_gain;
                    n_state     = ST_IDLE;
                end else begin
                    n_mid   = s_nlo;
                    e_raddr = s_nlo[EA-1:0];
                    n_state = ST_E_SEG0;
                end
            end
            ST_E_SEG0: begin
                if (e_gap) begin
                    n_out_valid = 1'b1;
                    n_gain      = r_missing_gain;
                    n_state     = ST_IDLE;
                end else begin
                    n_lo    = SW'(e_start);
                    e_raddr = r_mid[EA-1:0] + EA'(1);
                    n_state = ST_E_SEG1;
                end
            end
            ST_E_SEG1: begin
                n_hi      = s_end;
                n_seg_end = s_end;
                if (r_lo >= s_end) begin
                    n_out_valid = 1'b1;
                    n_gain      = r_missing_gain;
                    n_state     = ST_IDLE;
                end else begin
                    n_mid   = s_sum_end[SW:1];
                    b_raddr = s_sum_end[BA:1];
                    n_state = ST_B_SRCH;
                end
            end
            ST_B_SRCH: begin
                if (s_more) begin
                    n_lo    = s_nlo;
                    n_hi    = s_nhi;
                    n_mid   = s_nmid;
                    b_raddr = s_nmid[BA-1:0];
                end else if (s_nlo == r_seg_end) begin
                    n_out_valid = 1'b1;
                    n_gain      = r_missing_gain;
                    n_state     = ST_IDLE;
                end else begin
                    n_mid   = s_nlo;
                    b_raddr = s_nlo[BA-1:0];
                    n_state = ST_B_GAIN;
                end
            end
            ST_B_GAIN: begin
                n_out_valid = 1'b1;
                n_gain      = b_gap ? r_missing_gain : b_gain;
                n_hit       = !b_gap;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_elev_count   <= '0;
            r_bear_count   <= '0;
            r_out_valid    <= 1'b0;
            r_missing_gain <= '0;
        end else begin
            r_state      <= n_state;
            r_elev_count <= n_elev_count;
            r_bear_count <= n_bear_count;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_missing_gain <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_elev_key  <= n_last_elev_key;
        r_last_seg_start <= n_last_seg_start;
        r_last_bear_key  <= n_last_bear_key;
        r_q_elev         <= n_q_elev;
        r_q_bear         <= n_q_bear;
        r_lo             <= n_lo;
        r_hi             <= n_hi;
        r_mid            <= n_mid;
        r_seg_end        <= n_seg_end;
        r_gain           <= n_gain;
        r_hit            <= n_hit;
        r_status         <= n_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_gain_out  = r_gain;
    assign o_hit       = r_hit;
    assign o_status    = r_status;

    a_elev_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elev_count <= EC'(ELEV_ENTRIES))
        else $error("Elevation count exceeds table depth.");

    a_bear_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bear_count <= BC'(BEAR_ENTRIES))
        else $error("Bearing count exceeds table depth.");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_out_valid)
        else $error("Result pending while a query is still searching.");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_E_SRCH || r_state == ST_B_SRCH) |-> (r_lo <= r_mid && r_mid < r_hi))
        else $error("Search midpoint outside the current window.");

    a_hit_on_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_hit) |-> (r_status == agrl_pkg::STATUS_OK))
        else $error("Hit flagged together with a load error status.");

endmodule
